>>> hdl/utf8_punctuation_to_ascii_defines.svh
// Assertion helpers shared by the front and queue modules.
// Each expects clk_i and rst_ni to be visible where it is used.
`ifndef UTF8_PUNCTUATION_TO_ASCII_DEFINES_SVH
`define UTF8_PUNCTUATION_TO_ASCII_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define U8P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define U8P_ASSERT_NEVER(lbl, cond, msg) \
  `U8P_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/u8p_pkg.sv
package u8p_pkg;

  // Lead and continuation bytes of the mapped sequences
  localparam logic [7:0] LEAD_C2 = 8'hC2;
  localparam logic [7:0] LEAD_C3 = 8'hC3;
  localparam logic [7:0] LEAD_E2 = 8'hE2;
  localparam logic [7:0] NBSP_B1 = 8'hA0;
  localparam logic [7:0] MULT_B1 = 8'h97;
  localparam logic [7:0] GEN_B1  = 8'h80;
  localparam logic [7:0] MATH_B1 = 8'h88;
  localparam logic [7:0] DING_B1 = 8'h9D;
  localparam logic [7:0] MINUS_B2 = 8'h92;
  localparam logic [7:0] ELLIP_B2 = 8'hA6;

  // ASCII replacements
  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_X     = 8'h78;
  localparam logic [7:0] ASC_DASH  = 8'h2D;
  localparam logic [7:0] ASC_APOS  = 8'h27;
  localparam logic [7:0] ASC_QUOTE = 8'h22;
  localparam logic [7:0] ASC_DOT   = 8'h2E;

  // Group queue between front and back
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);

  // Output bytes caused by one input transaction
  typedef struct packed {
    logic [2:0][7:0] bytes;  // bytes[0] goes out first
    logic [1:0]      cnt;    // 1..3 valid bytes
    logic            last;   // string ends with this group
  } group_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

>>> hdl/u8p_front.sv
`include "utf8_punctuation_to_ascii_defines.svh"

module u8p_front
  import u8p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  fifo_stat_t stat_i,
  output logic       in_ready_o,
  output logic       push_o,
  output group_t     push_data_o
);

  logic [1:0] held_cnt_q, held_cnt_d;
  logic [7:0] held0_q, held0_d, held1_q, held1_d;
  logic [7:0] buf_b [5];
  group_t     grp_c;
  logic       acc;

  assign in_ready_o = !stat_i.full;
  assign acc        = in_valid_i && in_ready_o;

  // Window of held bytes plus the new byte
  always_comb begin
    for (int j = 0; j < 5; j++) buf_b[j] = 8'h00;
    case (held_cnt_q)
      2'd0: begin
        buf_b[0] = in_byte_i;
      end
      2'd1: begin
        buf_b[0] = held0_q;
        buf_b[1] = in_byte_i;
      end
      default: begin
        buf_b[0] = held0_q;
        buf_b[1] = held1_q;
        buf_b[2] = in_byte_i;
      end
    endcase
  end

  // Resolve the window: up to three match attempts
  always_comb begin : classify
    logic [1:0] n, pos, rem, cnt, k, adv;
    logic [2:0] p3;
    logic [7:0] b0, b1, b2, ch;
    logic       stop, brk;
    n    = (held_cnt_q == 2'd3) ? 2'd3 : held_cnt_q + 2'd1;
    pos  = 2'd0;
    cnt  = 2'd0;
    stop = 1'b0;
    grp_c = '0;
    for (int it = 0; it < 3; it++) begin
      p3  = {1'b0, pos};
      rem = n - pos;
      b0  = buf_b[p3];
      b1  = buf_b[p3 + 3'd1];
      b2  = buf_b[p3 + 3'd2];
      ch  = b0;
      k   = 2'd1;
      adv = 2'd1;
      brk = 1'b0;
      if (!stop && (pos < n)) begin
        if (b0 == LEAD_C2 || b0 == LEAD_C3) begin
          if (rem < 2'd2) begin
            brk = !in_last_i;
          end else if (b0 == LEAD_C2 && b1 == NBSP_B1) begin
            ch  = ASC_SPACE;
            adv = 2'd2;
          end else if (b0 == LEAD_C3 && b1 == MULT_B1) begin
            ch  = ASC_X;
            adv = 2'd2;
          end
        end else if (b0 == LEAD_E2) begin
          if (rem < 2'd2) begin
            brk = !in_last_i;
          end else if (!(b1 inside {GEN_B1, MATH_B1, DING_B1})) begin
            // early mismatch: lead byte goes out raw
          end else if (rem < 2'd3) begin
            brk = !in_last_i;
          end else if (b1 == GEN_B1) begin
            adv = 2'd3;
            if (b2 inside {[8'h90:8'h93]}) begin
              ch = ASC_DASH;
            end else if (b2 inside {8'h94, 8'h95}) begin
              ch = ASC_DASH;
              k  = 2'd2;
            end else if (b2 inside {[8'h98:8'h9B]}) begin
              ch = ASC_APOS;
            end else if (b2 inside {[8'h9C:8'h9F]}) begin
              ch = ASC_QUOTE;
            end else if (b2 == ELLIP_B2) begin
              ch = ASC_DOT;
              k  = 2'd3;
            end else begin
              adv = 2'd1;
            end
          end else if (b1 == MATH_B1) begin
            if (b2 == MINUS_B2) begin
              ch  = ASC_DASH;
              adv = 2'd3;
            end
          end else begin
            if (b2 inside {8'h9B, 8'h9C}) begin
              ch  = ASC_APOS;
              adv = 2'd3;
            end else if (b2 inside {8'h9D, 8'h9E}) begin
              ch  = ASC_QUOTE;
              adv = 2'd3;
            end
          end
        end
        if (brk) begin
          stop = 1'b1;
        end else begin
          for (int j = 0; j < 3; j++) begin
            if ((2'(j) < k) && (cnt != 2'd3)) begin
              grp_c.bytes[cnt] = ch;
              cnt = cnt + 2'd1;
            end
          end
          pos = pos + adv;
        end
      end
    end
    grp_c.cnt  = cnt;
    grp_c.last = in_last_i;
    held_cnt_d = n - pos;
    held0_d    = buf_b[{1'b0, pos}];
    held1_d    = buf_b[{1'b0, pos} + 3'd1];
  end

  assign push_o      = acc && (grp_c.cnt != 2'd0);
  assign push_data_o = grp_c;

  // Pending prefix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      held0_q    <= 8'h00;
      held1_q    <= 8'h00;
    end else if (acc) begin
      held_cnt_q <= held_cnt_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
    end
  end

  `U8P_ASSERT_NEVER(a_held_range, held_cnt_q == 2'd3, "held count out of range")
  `U8P_ASSERT(a_last_flush, acc && in_last_i |=> held_cnt_q == 2'd0, "prefix kept after end")

endmodule

>>> hdl/u8p_fifo.sv
`include "utf8_punctuation_to_ascii_defines.svh"

module u8p_fifo
  import u8p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  group_t     push_data_i,
  input  logic       pop_i,
  output group_t     head_o,
  output fifo_stat_t stat_o
);

  group_t           mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (PTR_W+1)'(QDEPTH));
  assign head_o       = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

  `U8P_ASSERT_NEVER(a_no_overflow, push_i && stat_o.full, "push into full queue")
  `U8P_ASSERT_NEVER(a_no_underflow, pop_i && stat_o.empty, "pop from empty queue")
  `U8P_ASSERT_NEVER(a_level, count_q > (PTR_W+1)'(QDEPTH), "queue level past depth")

endmodule

>>> hdl/u8p_back.sv
module u8p_back
  import u8p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  group_t     head_i,
  input  fifo_stat_t stat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load, at_end;

  // Load the next byte whenever the queue holds a group and the output register is free
  assign load   = !stat_i.empty && (!vld_q || out_ready_i);
  assign at_end = (idx_q == head_i.cnt - 2'd1);
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && !out_ready_i;
    byte_d = byte_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      byte_d = head_i.bytes[idx_q];
      last_d = head_i.last && at_end;
      idx_d  = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

>>> hdl/utf8_punctuation_to_ascii.sv
// UTF-8 punctuation to ASCII rewriter.
// Input stream s_axis: one text byte per transaction, tlast on the final
// byte of a string. Output stream m_axis: one normalized byte per
// transaction, tlast on the final output byte of the string.
// A front stage classifies each byte against the held prefix (up to two
// bytes) and produces a group of zero to three output bytes; groups wait in
// a four-entry queue; a back stage sends them out one byte per cycle, while
// m_axis is ready, from an output register.
// A byte that resolves passes through the queue and the output register
// before it appears on m_axis. Throughput: one input transaction per cycle
// while each byte yields at most one output byte and m_axis is ready; the
// single-byte output port sets the rate, so two- and three-byte expansions
// leave one byte at a time and the queue absorbs them.
// s_axis_tready drops only while the queue is full; a stall on m_axis
// fills the queue and then stalls the input.
// Reset empties the queue, drops any held prefix and clears m_axis_tvalid.
module utf8_punctuation_to_ascii
  import u8p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  logic       push, pop;
  group_t     push_data, head;
  fifo_stat_t stat;

  u8p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  u8p_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (stat)
  );

  u8p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> tb/utf8_punctuation_to_ascii_checker.sv
// Watches both streams of the punctuation rewriter, predicts the output text
// from every accepted input byte and compares it byte by byte.
module utf8_punctuation_to_ascii_checker
  import u8p_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tlast,   // out_last
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Third-byte ranges of the E2 sequences
  localparam logic [7:0] HYPH_LO    = 8'h90;
  localparam logic [7:0] HYPH_HI    = 8'h93;
  localparam logic [7:0] EMDASH_LO  = 8'h94;
  localparam logic [7:0] EMDASH_HI  = 8'h95;
  localparam logic [7:0] SQUOTE_LO  = 8'h98;
  localparam logic [7:0] SQUOTE_HI  = 8'h9B;
  localparam logic [7:0] DQUOTE_LO  = 8'h9C;
  localparam logic [7:0] DQUOTE_HI  = 8'h9F;
  localparam logic [7:0] DING_SQ_LO = 8'h9B;
  localparam logic [7:0] DING_SQ_HI = 8'h9C;
  localparam logic [7:0] DING_DQ_LO = 8'h9D;
  localparam logic [7:0] DING_DQ_HI = 8'h9E;
  localparam int         MAX_OUT    = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // Predictor state: pending prefix and the expected output text
  logic [7:0]  prefix_q [2];
  int unsigned prefix_len = 0;
  text_beat_t  text_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned pending = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = pending;

  // ASCII replacement for an E2 sequence; returns how often it repeats
  function automatic int unsigned e2_repeat(input logic [7:0] b1, input logic [7:0] b2,
                                            output logic [7:0] ch);
    ch = 8'h00;
    if (b1 == GEN_B1) begin
      if (b2 >= HYPH_LO && b2 <= HYPH_HI) begin
        ch = ASC_DASH;
        return 1;
      end
      if (b2 >= EMDASH_LO && b2 <= EMDASH_HI) begin
        ch = ASC_DASH;
        return 2;
      end
      if (b2 >= SQUOTE_LO && b2 <= SQUOTE_HI) begin
        ch = ASC_APOS;
        return 1;
      end
      if (b2 >= DQUOTE_LO && b2 <= DQUOTE_HI) begin
        ch = ASC_QUOTE;
        return 1;
      end
      if (b2 == ELLIP_B2) begin
        ch = ASC_DOT;
        return 3;
      end
    end else if (b1 == MATH_B1 && b2 == MINUS_B2) begin
      ch = ASC_DASH;
      return 1;
    end else if (b1 == DING_B1) begin
      if (b2 >= DING_SQ_LO && b2 <= DING_SQ_HI) begin
        ch = ASC_APOS;
        return 1;
      end
      if (b2 >= DING_DQ_LO && b2 <= DING_DQ_HI) begin
        ch = ASC_QUOTE;
        return 1;
      end
    end
    return 0;
  endfunction

  // Resolve the held prefix plus one new byte into output bytes
  function automatic void rewrite_byte(input logic [7:0] in_b, input logic fin);
    logic [7:0]  win [3];
    logic [7:0]  res [$];
    logic [7:0]  ch;
    text_beat_t  beat;
    int unsigned n;
    int unsigned pos;
    int unsigned rem;
    int unsigned k;
    int unsigned nout;
    for (int i = 0; i < 3; i++) win[i] = 8'h00;
    for (int i = 0; i < int'(prefix_len); i++) win[i] = prefix_q[i];
    win[prefix_len] = in_b;
    n   = prefix_len + 1;
    pos = 0;
    while (pos < n) begin
      rem = n - pos;
      if (win[pos] == LEAD_C2 || win[pos] == LEAD_C3) begin
        if (rem < 2) begin
          if (!fin) break;
          res = {res, win[pos]};
          pos++;
        end else if (win[pos] == LEAD_C2 && win[pos+1] == NBSP_B1) begin
          res = {res, ASC_SPACE};
          pos += 2;
        end else if (win[pos] == LEAD_C3 && win[pos+1] == MULT_B1) begin
          res = {res, ASC_X};
          pos += 2;
        end else begin
          res = {res, win[pos]};
          pos++;
        end
      end else if (win[pos] == LEAD_E2) begin
        if (rem < 2) begin
          if (!fin) break;
          res = {res, win[pos]};
          pos++;
        end else if (win[pos+1] != GEN_B1 && win[pos+1] != MATH_B1 &&
                     win[pos+1] != DING_B1) begin
          // second byte rules out every E2 mapping: release the lead now
          res = {res, win[pos]};
          pos++;
        end else if (rem < 3) begin
          if (!fin) break;
          res = {res, win[pos]};
          pos++;
        end else begin
          k = e2_repeat(win[pos+1], win[pos+2], ch);
          if (k > 0) begin
            repeat (k) res = {res, ch};
            pos += 3;
          end else begin
            res = {res, win[pos]};
            pos++;
          end
        end
      end else begin
        res = {res, win[pos]};
        pos++;
      end
    end

    prefix_len  = n - pos;
    prefix_q[0] = 8'h00;
    prefix_q[1] = 8'h00;
    for (int i = 0; i < int'(prefix_len); i++) prefix_q[i] = win[pos + i];

    nout = (res.size() > MAX_OUT) ? MAX_OUT : res.size();
    for (int i = 0; i < int'(nout); i++) begin
      beat.data = res[i];
      beat.last = fin && (i == int'(nout) - 1);
      text_q = {text_q, beat};
    end
  endfunction

  // Predict on input transactions, then check output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    if (!rst_ni) begin
      prefix_len  = 0;
      prefix_q[0] = 8'h00;
      prefix_q[1] = 8'h00;
      text_q.delete();
      pending = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) rewrite_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (text_q.size() == 0) begin
          $error("out_byte: no byte expected, got 8'h%02h (tlast %0b)",
                 m_axis_tdata, m_axis_tlast);
          mismatch_cnt++;
        end else begin
          want = text_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h", want.data, m_axis_tdata);
            mismatch_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatch_cnt++;
          end
        end
      end
      pending = text_q.size();
    end
  end

endmodule

>>> tb/utf8_punctuation_to_ascii_tb.sv
// Drives text strings into the punctuation rewriter with random idling on
// both streams and reports the verdict from the checker's count.
module utf8_punctuation_to_ascii_tb
  import u8p_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_GOAL    = 400;
  localparam int unsigned STALL_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned BURST_LEN    = 30;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  // Continuation bytes for well-formed sequences, plus plain and extreme byte values
  localparam logic [7:0] HYPH_LO     = 8'h90;
  localparam logic [7:0] EMDASH_HI   = 8'h95;
  localparam logic [7:0] SQUOTE_LO   = 8'h98;
  localparam logic [7:0] DQUOTE_HI   = 8'h9F;
  localparam logic [7:0] DING_LO     = 8'h9B;
  localparam logic [7:0] DING_HI     = 8'h9E;
  localparam logic [7:0] EM_DASH_B2  = 8'h94;
  localparam logic [7:0] DING_SQ_B2  = 8'h9C;
  localparam logic [7:0] TXT_A       = 8'h41;
  localparam logic [7:0] MIN_BYTE    = 8'h01;
  localparam logic [7:0] MAX_BYTE    = 8'hFF;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;    // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // out_last

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned items_sent = 0;
  bit          gaps_off = 1'b0;
  bit          stall_req = 1'b0;
  logic [7:0]  text_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utf8_punctuation_to_ascii i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  utf8_punctuation_to_ascii_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // Sender gap: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_lead();
    case ($urandom_range(0, 2))
      0:       return LEAD_C2;
      1:       return LEAD_C3;
      default: return LEAD_E2;
    endcase
  endfunction

  // One input transaction, preceded by a random gap
  task automatic put_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) put_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Hold the input idle until every predicted byte has left the block
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Append plain text, a mapped sequence, a near miss or raw noise
  task automatic add_token();
    int unsigned r;
    logic [7:0]  lead;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      text_q = {text_q, 8'($urandom_range(PRINT_LO, PRINT_HI))};
    end else if (r < 75) begin
      case ($urandom_range(0, 6))
        0: text_q = {text_q, LEAD_C2, NBSP_B1};
        1: text_q = {text_q, LEAD_C3, MULT_B1};
        2: text_q = {text_q, LEAD_E2, GEN_B1, 8'($urandom_range(HYPH_LO, EMDASH_HI))};
        3: text_q = {text_q, LEAD_E2, GEN_B1, 8'($urandom_range(SQUOTE_LO, DQUOTE_HI))};
        4: text_q = {text_q, LEAD_E2, GEN_B1, ELLIP_B2};
        5: text_q = {text_q, LEAD_E2, MATH_B1, MINUS_B2};
        default: text_q = {text_q, LEAD_E2, DING_B1, 8'($urandom_range(DING_LO, DING_HI))};
      endcase
    end else if (r < 90) begin
      lead = pick_lead();
      case ($urandom_range(0, 3))
        0: text_q = {text_q, lead, 8'($urandom_range(1, 255))};
        1: text_q = {text_q, LEAD_E2, 8'($urandom_range(1, 255))};
        2: begin
          case ($urandom_range(0, 2))
            0:       text_q = {text_q, LEAD_E2, GEN_B1};
            1:       text_q = {text_q, LEAD_E2, MATH_B1};
            default: text_q = {text_q, LEAD_E2, DING_B1};
          endcase
          text_q = {text_q, 8'($urandom_range(1, 255))};
        end
        // lone lead: resolved by the next token or flushed at end of string
        default: text_q = {text_q, lead};
      endcase
    end else begin
      text_q = {text_q, 8'($urandom_range(1, 255))};
    end
  endtask

  // Receiver: random ready/stall runs, plus one long hold-off on request
  initial begin
    int unsigned run;
    int unsigned r;
    bit          rdy;
    run = 0;
    rdy = 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        stall_req = 1'b0;
        rdy = 1'b0;
        run = 0;
      end else if (run == 0) begin
        rdy = !rdy;
        m_axis_tready <= rdy;
        r = $urandom_range(0, 99);
        if (rdy) run = (r < 70) ? $urandom_range(1, 8) :
                       (r < 90) ? $urandom_range(10, 40) : $urandom_range(50, 150);
        else     run = (r < 80) ? $urandom_range(1, 3) : $urandom_range(8, 25);
      end else begin
        run--;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    bit pressure_done;
    bit drain_done;
    int unsigned ntok;
    pressure_done = 1'b0;
    drain_done    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, every mapping family, early mismatch and end-of-string flush
    text_q = '{MIN_BYTE, MAX_BYTE, LEAD_C2, NBSP_B1};
    send_text();
    text_q = '{LEAD_C3, MULT_B1, LEAD_E2, GEN_B1, EM_DASH_B2, LEAD_E2, GEN_B1, ELLIP_B2};
    send_text();
    text_q = '{LEAD_E2, MATH_B1, MINUS_B2, LEAD_E2, DING_B1, DING_SQ_B2, LEAD_E2, TXT_A};
    send_text();
    text_q = '{LEAD_C2, LEAD_E2, GEN_B1};
    send_text();
    wait_drained();

    // Random strings
    while (items_sent < ITEM_GOAL) begin
      gaps_off = (items_sent >= 300 && items_sent < 340);
      if (!drain_done && items_sent >= 120) begin
        wait_drained();
        drain_done = 1'b1;
      end
      if (!pressure_done && items_sent >= 200) begin
        // back-to-back burst against a stalled output fills the block
        gaps_off  = 1'b1;
        stall_req = 1'b1;
        while (text_q.size() < BURST_LEN) add_token();
        pressure_done = 1'b1;
      end else begin
        ntok = $urandom_range(1, 10);
        repeat (ntok) add_token();
      end
      send_text();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("utf8_punctuation_to_ascii regression: pass");
    end else begin
      $display("utf8_punctuation_to_ascii regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("utf8_punctuation_to_ascii regression: fail");
    $finish;
  end

endmodule
